>>> rtl/attitude_frame_deframer_assert.svh
// assertion macros for the attitude frame deframer
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef ATTITUDE_FRAME_DEFRAMER_ASSERT_SVH
`define ATTITUDE_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define AFD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("afd invariant violated");
// consequence holds in the cycle after the antecedent
`define AFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afd sequence violated");
`else
`define AFD_ASSERT_ALWAYS(lbl, cond)
`define AFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/afd_pkg.sv
// shared types and constants for the attitude frame deframer
// no dependencies
`default_nettype none
package afd_pkg;
    localparam int unsigned FRAME_LEN  = 12;
    localparam int unsigned WIN_DEPTH  = FRAME_LEN - 1;
    localparam int unsigned FILL_W     = 4;
    localparam logic [7:0]  SYNC_A     = 8'hAA;
    localparam logic [7:0]  SYNC_B     = 8'h55;
    localparam logic [7:0]  TYPE_ATT   = 8'h06;
    localparam int unsigned SUM_FIRST  = 2;
    localparam int unsigned TYPE_POS   = 4;
    localparam int unsigned YAW_POS    = 5;
    localparam int unsigned PITCH_POS  = 7;
    localparam int unsigned ROLL_POS   = 9;

    typedef logic [7:0] byte_t;
    typedef byte_t window_t [WIN_DEPTH];

    typedef struct packed {
        logic               match;
        logic [15:0]        yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } frame_check_t;
endpackage
`default_nettype wire

>>> rtl/afd_check.sv
// frame test on the stored 11 bytes plus the arriving checksum byte
// depends on afd_pkg
`default_nettype none
module afd_check (
    input  var afd_pkg::window_t      win,
    input  wire [7:0]                 last_byte,
    output afd_pkg::frame_check_t     chk
);
    import afd_pkg::*;

    logic [7:0] sum;

    // wrapping sum of bytes 2 to 10
    always_comb
    begin
        sum = '0;
        for (int i = SUM_FIRST; i < WIN_DEPTH; i++)
        begin
            sum = sum + win[i];
        end
    end

    always_comb
    begin
        chk.match = (win[0] == SYNC_A) && (win[1] == SYNC_B)
                    && (win[TYPE_POS] == TYPE_ATT) && (sum == last_byte);
        chk.yaw   = {win[YAW_POS + 1], win[YAW_POS]};
        chk.pitch = {win[PITCH_POS + 1], win[PITCH_POS]};
        chk.roll  = {win[ROLL_POS + 1], win[ROLL_POS]};
    end
endmodule
`default_nettype wire

>>> rtl/attitude_frame_deframer.sv
// attitude frame deframer top level: byte window, frame test, result register
// depends on afd_pkg, afd_check and attitude_frame_deframer_assert.svh
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   input    | in        | in_valid / in_ready  | rx_byte
//   result   | out       | out_valid/ out_ready | yaw, pitch, roll centideg, good_frames
//
// one byte is taken per cycle unless a stalled result holds the input; the frame test is a single pass of compare and
// a nine-byte add tree between the window registers and the result register
// a new request is taken whenever the result register is empty or being drained
// reset empties the window, clears the frame count and drops any pending result
// a stalled result holds the input side and with it the window
`default_nettype none
module attitude_frame_deframer (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [7:0]          rx_byte,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [15:0]        yaw_centideg,
    output logic signed [15:0] pitch_centideg,
    output logic signed [15:0] roll_centideg,
    output logic [31:0]        good_frames
);
    import afd_pkg::*;

    // bytes 0 to 10 of the candidate frame; byte 11 is the arriving byte
    window_t              win_reg;
    window_t              win_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [31:0]          frames_reg;
    logic [31:0]          frames_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [15:0]          yaw_reg;
    logic signed [15:0]   pitch_reg;
    logic signed [15:0]   roll_reg;
    logic [31:0]          good_reg;

    frame_check_t         chk;
    logic                 in_take;
    logic                 window_full;
    logic                 emit;

    afd_check u_check (
        .win       (win_reg),
        .last_byte (rx_byte),
        .chk       (chk)
    );

    // result register frees itself when drained, so back to back requests flow
    assign in_ready    = !out_valid_reg || out_ready;
    assign in_take     = in_valid && in_ready;
    assign window_full = (fill_reg == FILL_W'(WIN_DEPTH));
    assign emit        = in_take && window_full && chk.match;

    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        frames_next    = frames_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_take)
        begin
            if (!window_full)
            begin
                // still filling: store at the fill position
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    if (fill_reg == FILL_W'(i))
                    begin
                        win_next[i] = rx_byte;
                    end
                end
                fill_next = fill_reg + 1'b1;
            end
            else if (chk.match)
            begin
                // good frame: count it and start over
                fill_next      = '0;
                frames_next    = frames_reg + 32'd1;
                out_valid_next = 1'b1;
            end
            else
            begin
                // resync: drop the oldest byte and slide the window down
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[WIN_DEPTH - 1] = rx_byte;
                fill_next               = FILL_W'(WIN_DEPTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (emit)
        begin
            yaw_reg   <= chk.yaw;
            pitch_reg <= chk.pitch;
            roll_reg  <= chk.roll;
            good_reg  <= frames_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign yaw_centideg   = yaw_reg;
    assign pitch_centideg = pitch_reg;
    assign roll_centideg  = roll_reg;
    assign good_frames    = good_reg;

`include "attitude_frame_deframer_assert.svh"

    // window never holds a full frame between requests
    `AFD_ASSERT_ALWAYS(a_fill_range, fill_reg <= FILL_W'(WIN_DEPTH))
    // a good frame empties the window and raises a result
    `AFD_ASSERT_NEXT(a_emit_clears, emit, (fill_reg == '0) && out_valid_reg)
    // the frame count moves by exactly one on a good frame
    `AFD_ASSERT_NEXT(a_count_step, emit, frames_reg == $past(frames_reg) + 32'd1)
    // while a result is pending, the result count matches the running count
    `AFD_ASSERT_ALWAYS(a_count_match, !out_valid_reg || (good_reg == frames_reg))
endmodule
`default_nettype wire
